FILE: src/cut_quadrant_byte_codec_core_defines.svh
// Assertion shorthands shared by the codec RTL.
// Each macro assumes the enclosing module has clk_i and rst_ni.
`ifndef CUT_QUADRANT_BYTE_CODEC_CORE_DEFINES_SVH
`define CUT_QUADRANT_BYTE_CODEC_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CQBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CQBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cqbc_pkg.sv
package cqbc_pkg;

  localparam int unsigned NQUAD = 4;
  localparam int unsigned NCODE = 77;

  // Quadrant codes; values above the last quadrant mean no quadrant.
  localparam logic [2:0] NO_QUAD   = 3'd4;
  localparam logic [2:0] NULL_QUAD = 3'd2;

  localparam logic [7:0] NULL_CODE = 8'hc1;
  localparam logic [7:0] CODE_LO   = 8'h40;
  localparam logic [7:0] CODE_HI   = 8'hf9;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_EOF    = 8'h1a;

  // Configuration register indexes.
  localparam logic CFG_IDX_ASCII = 1'b0;
  localparam logic CFG_IDX_CRLF  = 1'b1;

  typedef enum logic [1:0] {
    REQ_DECODE = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_START  = 2'd2
  } cqbc_req_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BAD_SEL = 2'd1,
    ERR_RANGE   = 2'd2,
    ERR_NO_ENC  = 2'd3
  } cqbc_err_e;

  // Codec state as held in the state RAM.
  typedef struct packed {
    logic [2:0] quad;
    logic       prev_cr;
  } cqbc_state_t;

  localparam cqbc_state_t STATE_RESET = '{quad: NO_QUAD, prev_cr: 1'b0};

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] err;
  } cqbc_res_t;

  // Results caused by one item, first result in entry 0.
  typedef struct packed {
    logic [2:0]           cnt;
    cqbc_res_t [3:0]      res;
  } cqbc_batch_t;

  typedef struct packed {
    logic       found;
    logic [6:0] ix;
  } cqbc_hit_t;

  // Output of encoding one local byte.
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0]      quad;
    cqbc_res_t [1:0] r;
  } cqbc_enc_t;

  localparam logic [7:0] SEL_TAB [NQUAD] = '{8'h5e, 8'h7e, 8'h5c, 8'h7d};

  // Row 0 also gives the host code byte of each index.
  localparam logic [7:0] QUAD_TAB [NQUAD][NCODE] = '{
    '{8'h40,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hd1,8'hd2,
      8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'he2,8'he3,8'he4,8'he5,8'he6,
      8'he7,8'he8,8'he9,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
      8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'ha2,8'ha3,8'ha4,
      8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,
      8'hf7,8'hf8,8'hf9,8'h6c,8'h50,8'h6d,8'h4d,8'h5d,8'h4c,8'h4e,8'h6b,8'h60,
      8'h4b,8'h61,8'h7a,8'h6e,8'h6f},
    '{8'h20,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h4b,
      8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
      8'h58,8'h59,8'h5a,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
      8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,
      8'h76,8'h77,8'h78,8'h79,8'h7a,8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
      8'h37,8'h38,8'h39,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,
      8'h2e,8'h2f,8'h3a,8'h3b,8'h3f},
    '{8'h00,8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
      8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,
      8'h17,8'h18,8'h19,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h3c,8'h3d,8'h3e,8'h00,8'hfa,8'hfb,8'hfc,
      8'hfd,8'hfe,8'hff,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h1a,8'h1b,8'h1c,8'h1d,
      8'h1e,8'h1f,8'h00,8'h00,8'h00},
    '{8'h00,8'ha0,8'ha1,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,8'he0,8'he1,8'haa,
      8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
      8'hb7,8'hb8,8'hb9,8'h80,8'h00,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hc0,
      8'h00,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h00,8'hda,8'hdb,8'hdc,
      8'hdd,8'hde,8'hdf,8'hd0,8'h00,8'h00,8'h21,8'h22,8'h23,8'h24,8'h5b,8'h5c,
      8'h00,8'h5e,8'h5f,8'h00,8'h9c,8'h9d,8'h9e,8'h9f,8'hba,8'hbb,8'hbc,8'hbd,
      8'hbe,8'hbf,8'h9a,8'h9b,8'h00}
  };

  // First index of a byte in one quadrant row; a constant lookup after folding.
  function automatic cqbc_hit_t find_in(logic [1:0] k, logic [7:0] c);
    cqbc_hit_t h;
    h = '0;
    for (int i = NCODE - 1; i >= 0; i--) begin
      if (QUAD_TAB[k][i] == c) begin
        h.found = 1'b1;
        h.ix    = 7'(i);
      end
    end
    return h;
  endfunction

  // Quadrant chosen by a selector byte, or no quadrant.
  function automatic logic [2:0] sel_index(logic [7:0] c);
    logic [2:0] q;
    q = NO_QUAD;
    for (int k = NQUAD - 1; k >= 0; k--) begin
      if (SEL_TAB[k] == c) begin
        q = 3'(k);
      end
    end
    return q;
  endfunction

  // Encode one local byte against quadrant q (0 to 3, or none).
  function automatic cqbc_enc_t enc_one(logic [2:0] q, logic [7:0] c);
    cqbc_enc_t e;
    cqbc_hit_t hq;
    cqbc_hit_t hk;
    logic      done;
    e    = '0;
    done = 1'b0;
    e.quad = q;
    hq = find_in(q[1:0], c);
    if (c == 8'h00) begin
      // The literal zero always goes out as the null code of quadrant 2.
      e.quad = NULL_QUAD;
      if (q != NULL_QUAD) begin
        e.n         = 2'd2;
        e.r[0].data = SEL_TAB[NULL_QUAD[1:0]];
        e.r[1].data = NULL_CODE;
      end else begin
        e.n         = 2'd1;
        e.r[0].data = NULL_CODE;
      end
    end else if (q != NO_QUAD && hq.found) begin
      e.n         = 2'd1;
      e.r[0].data = QUAD_TAB[0][hq.ix];
    end else begin
      // Try every quadrant in order; the current one has already missed.
      for (int k = 0; k < NQUAD; k++) begin
        hk = find_in(2'(k), c);
        if (!done && hk.found) begin
          done        = 1'b1;
          e.quad      = 3'(k);
          e.n         = 2'd2;
          e.r[0].data = SEL_TAB[k];
          e.r[1].data = QUAD_TAB[0][hk.ix];
        end
      end
      if (!done) begin
        e.quad     = NO_QUAD;
        e.n        = 2'd1;
        e.r[0].err = ERR_NO_ENC;
      end
    end
    return e;
  endfunction

endpackage

FILE: src/cqbc_if.sv
// Request channel into the codec.
interface cqbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

// Result channel out of the codec.
interface cqbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_last;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output is_last, output error_code,
                  input ready);
  modport sink (input valid, input out_byte, input is_last, input error_code,
                output ready);
endinterface

FILE: src/cut_quadrant_byte_codec_core.sv
// Quadrant byte codec. Each request (decode a host code byte, encode a local
// byte, or start a transfer) is taken into an execute register while the codec
// state (current quadrant and last-byte-was-CR flag) is read from a small
// synchronous RAM; the request is then transformed, the new state is written
// back (bypassed to a request read in that same cycle) and its results, up to
// four, are loaded into a result queue that sends one result per cycle while
// the receiver is ready. A batch loads only into an empty queue, so a request
// with results waits in the execute register until the queue has drained; a
// request without results does not wait. The state RAM needs no clearing pass
// after reset: a flag marks it unwritten and the reset state is used until the
// first write.
module cut_quadrant_byte_codec_core import cqbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  cqbc_in_if.sink     in_i,
  cqbc_out_if.source  out_o
);

  `include "cut_quadrant_byte_codec_core_defines.svh"

  localparam int unsigned ST_W = $bits(cqbc_state_t);

  logic        ascii_q;
  logic        crlf_q;
  logic        xv_q;
  logic        xv_d;
  logic [1:0]  xreq_q;
  logic [7:0]  xbyte_q;
  logic        byp_q;
  logic        rvalid_q;
  logic        stv_q;
  cqbc_state_t byp_data_q;
  logic        acc;
  logic        exec_go;
  logic        q_empty;
  logic [ST_W-1:0] ram_rdata;
  cqbc_state_t cur_state;
  cqbc_state_t new_state;
  cqbc_batch_t batch;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_q <= 1'b0;
      crlf_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_ASCII) begin
        ascii_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_IDX_CRLF) begin
        crlf_q <= cfg_data_i;
      end
    end
  end

  // Execute when the batch has nowhere to clash with pending results.
  assign exec_go    = xv_q && (q_empty || batch.cnt == 3'd0);
  assign in_i.ready = !xv_q || exec_go;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    xv_d = xv_q;
    if (acc) begin
      xv_d = 1'b1;
    end else if (exec_go) begin
      xv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q     <= 1'b0;
      byp_q    <= 1'b0;
      rvalid_q <= 1'b0;
      stv_q    <= 1'b0;
    end else begin
      xv_q <= xv_d;
      if (exec_go) begin
        stv_q <= 1'b1;
      end
      // A write in the same cycle as the read is forwarded around the RAM.
      if (acc) begin
        byp_q    <= exec_go;
        rvalid_q <= stv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      xreq_q     <= in_i.req_type;
      xbyte_q    <= in_i.in_byte;
      byp_data_q <= new_state;
    end
  end

  // State word lives at entry 0; entry 1 is spare.
  cqbc_ram #(
    .WIDTH (ST_W),
    .DEPTH (2)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (exec_go),
    .waddr_i (1'b0),
    .wdata_i (new_state),
    .re_i    (acc),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (byp_q) begin
      cur_state = byp_data_q;
    end else if (rvalid_q) begin
      cur_state = cqbc_state_t'(ram_rdata);
    end else begin
      cur_state = STATE_RESET;
    end
  end

  cqbc_xform u_xform (
    .state_i (cur_state),
    .req_i   (xreq_q),
    .byte_i  (xbyte_q),
    .ascii_i (ascii_q),
    .crlf_i  (crlf_q),
    .batch_o (batch),
    .state_o (new_state)
  );

  cqbc_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (exec_go),
    .batch_i (batch),
    .empty_o (q_empty),
    .out_o   (out_o)
  );

  `CQBC_ASSERT_IMP(a_wb_quad_legal, exec_go, new_state.quad <= NO_QUAD, "illegal quadrant written")
  `CQBC_ASSERT_NXT(a_exec_holds, xv_q && !exec_go, xv_q && $stable(xbyte_q), "stalled request lost")

endmodule

FILE: src/cqbc_ram.sv
// Simple dual-port RAM with a registered read port.
module cqbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write first in source order, but the read returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cqbc_xform.sv
// Transform of one request against the current state: produces the batch of
// results and the state to write back.
module cqbc_xform import cqbc_pkg::*; (
  input  cqbc_state_t state_i,
  input  logic [1:0]  req_i,
  input  logic [7:0]  byte_i,
  input  logic        ascii_i,
  input  logic        crlf_i,
  output cqbc_batch_t batch_o,
  output cqbc_state_t state_o
);

  logic [2:0]  qn;
  logic [2:0]  sq;
  logic [2:0]  q_mid;
  logic [7:0]  vq;
  logic        cr_ins;
  logic        resel;
  logic        text_crlf;
  cqbc_hit_t   ci;
  cqbc_enc_t   e_cr;
  cqbc_enc_t   e_m;
  cqbc_batch_t batch;
  cqbc_state_t nstate;

  // Lookups for both directions.
  always_comb begin
    qn        = (state_i.quad < NO_QUAD) ? state_i.quad : NO_QUAD;
    ci        = find_in(2'd0, byte_i);
    vq        = QUAD_TAB[qn[1:0]][ci.ix];
    sq        = sel_index(byte_i);
    text_crlf = ascii_i && crlf_i;
    cr_ins    = text_crlf && !state_i.prev_cr && (byte_i == CH_LF);
    e_cr      = enc_one(qn, CH_CR);
    q_mid     = cr_ins ? e_cr.quad : qn;
    e_m       = enc_one(q_mid, byte_i);
  end

  // Request decode and result assembly.
  always_comb begin
    batch  = '0;
    nstate = state_i;
    resel  = 1'b0;
    unique case (req_i)
      REQ_DECODE: begin
        if (qn == NO_QUAD) begin
          resel = 1'b1;
        end else if (byte_i < CODE_LO || byte_i > CODE_HI) begin
          batch.cnt        = 3'd1;
          batch.res[0].err = ERR_RANGE;
        end else if (ci.found &&
                     !(qn != NULL_QUAD && byte_i != NULL_CODE && vq == 8'h00)) begin
          // CR and end-of-file bytes vanish in text mode with line-end handling.
          if (!(text_crlf && (vq == CH_CR || vq == CH_EOF))) begin
            batch.cnt         = 3'd1;
            batch.res[0].data = vq;
          end
        end else begin
          resel = 1'b1;
        end
        // With no current quadrant, or for an unmapped byte, the byte is taken as a quadrant selector.
        if (resel) begin
          nstate.quad = sq;
          if (sq == NO_QUAD) begin
            batch.cnt        = 3'd1;
            batch.res[0].err = ERR_BAD_SEL;
          end
        end
      end
      REQ_ENCODE: begin
        nstate.quad = e_m.quad;
        if (cr_ins) begin
          batch.cnt = {1'b0, e_cr.n} + {1'b0, e_m.n};
          if (e_cr.n == 2'd2) begin
            batch.res[0] = e_cr.r[0];
            batch.res[1] = e_cr.r[1];
            batch.res[2] = e_m.r[0];
            batch.res[3] = e_m.r[1];
          end else begin
            batch.res[0] = e_cr.r[0];
            batch.res[1] = e_m.r[0];
            batch.res[2] = e_m.r[1];
          end
        end else begin
          nstate.prev_cr = (byte_i == CH_CR);
          batch.cnt      = {1'b0, e_m.n};
          batch.res[0]   = e_m.r[0];
          batch.res[1]   = e_m.r[1];
        end
      end
      REQ_START: begin
        nstate.quad = NO_QUAD;
      end
      default: begin
        nstate = state_i;
      end
    endcase
  end

  assign batch_o = batch;
  assign state_o = nstate;

endmodule

FILE: src/cqbc_obuf.sv
// Four-entry result queue; entry 0 is presented on the result channel.
module cqbc_obuf import cqbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  cqbc_batch_t  batch_i,
  output logic         empty_o,
  cqbc_out_if.source   out_o
);

  `include "cut_quadrant_byte_codec_core_defines.svh"

  logic [2:0] cnt_q;
  logic [2:0] cnt_d;
  cqbc_res_t  ent_q [4];
  cqbc_res_t  ent_d [4];
  logic       pop;
  logic       fill;

  assign pop  = out_o.valid && out_o.ready;
  assign fill = load_i && (batch_i.cnt != 3'd0);

  // Load a whole batch into the empty queue, otherwise shift on each transfer.
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < 4; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (fill) begin
      cnt_d = batch_i.cnt;
      for (int i = 0; i < 4; i++) begin
        ent_d[i] = batch_i.res[i];
      end
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
      for (int i = 0; i < 3; i++) begin
        ent_d[i] = ent_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign empty_o          = (cnt_q == 3'd0);
  assign out_o.valid      = (cnt_q != 3'd0);
  assign out_o.out_byte   = ent_q[0].data;
  assign out_o.error_code = ent_q[0].err;
  assign out_o.is_last    = (cnt_q == 3'd1);

  `CQBC_ASSERT_IMP(a_fill_into_empty, fill, cnt_q == 3'd0, "batch loaded over pending results")
  `CQBC_ASSERT_NXT(a_last_drains, pop && cnt_q == 3'd1, cnt_q == 3'd0, "queue not empty after last")

endmodule

FILE: sim/cqbc_tb_pkg.sv
package cqbc_tb_pkg;
  import cqbc_pkg::*;

  // Request code that the codec has no use for.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Selector byte of each quadrant.
  localparam logic [7:0] SELECTOR_BYTE [NQUAD] = '{8'h5e, 8'h7e, 8'h5c, 8'h7d};

  // Local byte of every host code in each quadrant; row 0 doubles as the code list.
  localparam logic [7:0] CODE_MAP [NQUAD][NCODE] = '{
    '{8'h40,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hd1,8'hd2,
      8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'he2,8'he3,8'he4,8'he5,8'he6,
      8'he7,8'he8,8'he9,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
      8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'ha2,8'ha3,8'ha4,
      8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,
      8'hf7,8'hf8,8'hf9,8'h6c,8'h50,8'h6d,8'h4d,8'h5d,8'h4c,8'h4e,8'h6b,8'h60,
      8'h4b,8'h61,8'h7a,8'h6e,8'h6f},
    '{8'h20,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h4b,
      8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
      8'h58,8'h59,8'h5a,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
      8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,
      8'h76,8'h77,8'h78,8'h79,8'h7a,8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
      8'h37,8'h38,8'h39,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,
      8'h2e,8'h2f,8'h3a,8'h3b,8'h3f},
    '{8'h00,8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
      8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,
      8'h17,8'h18,8'h19,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h3c,8'h3d,8'h3e,8'h00,8'hfa,8'hfb,8'hfc,
      8'hfd,8'hfe,8'hff,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h1a,8'h1b,8'h1c,8'h1d,
      8'h1e,8'h1f,8'h00,8'h00,8'h00},
    '{8'h00,8'ha0,8'ha1,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,8'he0,8'he1,8'haa,
      8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
      8'hb7,8'hb8,8'hb9,8'h80,8'h00,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hc0,
      8'h00,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h00,8'hda,8'hdb,8'hdc,
      8'hdd,8'hde,8'hdf,8'hd0,8'h00,8'h00,8'h21,8'h22,8'h23,8'h24,8'h5b,8'h5c,
      8'h00,8'h5e,8'h5f,8'h00,8'h9c,8'h9d,8'h9e,8'h9f,8'hba,8'hbb,8'hbc,8'hbd,
      8'hbe,8'hbf,8'h9a,8'h9b,8'h00}
  };

  // One byte leaving the codec.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cqbc_err_e  err;
  } codec_byte_t;

  // Position of a byte in one quadrant row, or -1 when absent.
  function automatic int code_pos(int row, logic [7:0] b);
    for (int i = 0; i < NCODE; i++) begin
      if (CODE_MAP[row][i] == b) return i;
    end
    return -1;
  endfunction

  // Quadrant that a selector byte picks, or no quadrant at all.
  function automatic logic [2:0] quadrant_of_selector(logic [7:0] b);
    for (int q = 0; q < NQUAD; q++) begin
      if (SELECTOR_BYTE[q] == b) return 3'(q);
    end
    return NO_QUAD;
  endfunction

  // Tracks the codec state and holds the bytes still owed by the block.
  class codec_result_board;
    bit          ascii_on;
    bit          crlf_on;
    logic [2:0]  quad;
    bit          prev_cr;
    int unsigned mismatches;
    codec_byte_t owed_bytes[$];
    codec_byte_t batch[$];

    function new();
      ascii_on   = 1'b0;
      crlf_on    = 1'b0;
      quad       = NO_QUAD;
      prev_cr    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic value);
      if (idx == CFG_IDX_ASCII) ascii_on = value;
      else crlf_on = value;
    endfunction

    function int unsigned pending();
      return owed_bytes.size();
    endfunction

    function void push_result(logic [7:0] d, cqbc_err_e e);
      codec_byte_t r;
      r.data = d;
      r.last = 1'b0;
      r.err  = e;
      batch.push_back(r);
    endfunction

    function logic [2:0] current_quad();
      return (quad < NQUAD) ? quad : NO_QUAD;
    endfunction

    // Map one host code byte through the current quadrant.
    function void decode_host_byte(logic [7:0] c);
      logic [2:0] q;
      logic [7:0] v;
      int         ix;
      q = current_quad();
      if (q != NO_QUAD) begin
        if (c < CODE_LO || c > CODE_HI) begin
          push_result(8'h00, ERR_RANGE);
          return;
        end
        ix = code_pos(0, c);
        // Empty entries only count as data in the null quadrant or for the null code.
        if (ix >= 0 && (q == NULL_QUAD || c == NULL_CODE || CODE_MAP[q][ix] != 8'h00)) begin
          v = CODE_MAP[q][ix];
          if (!(ascii_on && crlf_on && (v == CH_CR || v == CH_EOF))) push_result(v, ERR_NONE);
          return;
        end
      end
      // Anything else is taken as a quadrant selector.
      quad = quadrant_of_selector(c);
      if (quad == NO_QUAD) push_result(8'h00, ERR_BAD_SEL);
    endfunction

    // Emit the code for one local byte, switching quadrant where needed.
    function void encode_local_byte(logic [7:0] c);
      logic [2:0] q;
      int         ix;
      q = current_quad();
      if (c == 8'h00) begin
        if (q != NULL_QUAD) begin
          quad = NULL_QUAD;
          push_result(SELECTOR_BYTE[NULL_QUAD], ERR_NONE);
        end
        push_result(NULL_CODE, ERR_NONE);
        return;
      end
      if (q != NO_QUAD) begin
        ix = code_pos(int'(q), c);
        if (ix >= 0) begin
          push_result(CODE_MAP[0][ix], ERR_NONE);
          return;
        end
      end
      for (int k = 0; k < NQUAD; k++) begin
        if (k == int'(q)) continue;
        ix = code_pos(k, c);
        if (ix < 0) continue;
        quad = 3'(k);
        push_result(SELECTOR_BYTE[k], ERR_NONE);
        push_result(CODE_MAP[0][ix], ERR_NONE);
        return;
      end
      quad = NO_QUAD;
      push_result(8'h00, ERR_NO_ENC);
    endfunction

    // Work out the bytes that one accepted request causes.
    function void note_request(logic [1:0] kind, logic [7:0] b);
      case (kind)
        REQ_DECODE: begin
          decode_host_byte(b);
        end
        REQ_ENCODE: begin
          // A bare LF gets a CR in front; the inserted CR leaves the flag alone.
          if (ascii_on && crlf_on && !prev_cr && b == CH_LF) encode_local_byte(CH_CR);
          else prev_cr = (b == CH_CR);
          encode_local_byte(b);
        end
        REQ_START: begin
          quad = NO_QUAD;
        end
        default: begin
        end
      endcase
      if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) owed_bytes.push_back(batch[i]);
      batch.delete();
    endfunction

    // Compare one transferred result with the oldest byte owed.
    function void check_result(logic [7:0] data, logic last, logic [1:0] err);
      codec_byte_t want;
      if (owed_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h is_last %0b error_code %0d", data, last, err);
        mismatches++;
        return;
      end
      want = owed_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("is_last: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
      if (err !== want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, err);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: sim/cut_quadrant_byte_codec_core_tb.sv
module cut_quadrant_byte_codec_core_tb;
  import cqbc_pkg::*;
  import cqbc_tb_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 46;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned IDLE_LIMIT      = 1000;
  localparam int unsigned NUM_PHASES      = 5;

  // Register settings per phase: ascii_mode in bit 1, crlf_mode in bit 0.
  localparam logic [1:0] PHASE_CFG [NUM_PHASES] = '{2'b11, 2'b00, 2'b10, 2'b01, 2'b11};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic        cfg_data_i;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_cycle = 0;
  int unsigned stall_mode  = 0;

  codec_result_board board;

  cqbc_in_if  req_if ();
  cqbc_out_if res_if ();

  cut_quadrant_byte_codec_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Offer one request and wait for its transfer; bursts are broken by random gaps.
  task automatic send_req(input logic [1:0] kind, input logic [7:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.in_byte  <= value;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(kind, value);
    burst_left--;
  endtask

  // Stop offering requests until every owed result has been transferred.
  task automatic hold_until_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the codec idle, so let any result-free request finish.
  task automatic write_config(input logic ascii_val, input logic crlf_val);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_ASCII;
    cfg_data_i <= ascii_val;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_IDX_CRLF;
    cfg_data_i <= crlf_val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    board.set_register(CFG_IDX_ASCII, ascii_val);
    board.set_register(CFG_IDX_CRLF, crlf_val);
  endtask

  // Hand-picked requests for ascii text with CR/LF handling on.
  task automatic directed_traffic();
    // Decoding: no quadrant, range limits, dropped bytes and empty entries.
    send_req(REQ_DECODE, CODE_LO);
    send_req(REQ_DECODE, SELECTOR_BYTE[0]);
    send_req(REQ_DECODE, CODE_LO - 8'd1);
    send_req(REQ_DECODE, CODE_HI + 8'd1);
    send_req(REQ_DECODE, 8'hff);
    send_req(REQ_DECODE, 8'h00);
    send_req(REQ_DECODE, NULL_CODE);
    send_req(REQ_DECODE, SELECTOR_BYTE[NULL_QUAD]);
    send_req(REQ_DECODE, 8'hd5);
    send_req(REQ_DECODE, 8'h4c);
    send_req(REQ_DECODE, CODE_LO);
    send_req(REQ_DECODE, CODE_HI);
    send_req(REQ_DECODE, SELECTOR_BYTE[3]);
    send_req(REQ_DECODE, 8'h82);
    send_req(REQ_UNUSED, 8'hff);
    send_req(REQ_START, 8'h00);
    // Encoding: the null byte, CR insertion and quadrant changes.
    send_req(REQ_ENCODE, 8'h00);
    send_req(REQ_ENCODE, 8'h00);
    send_req(REQ_ENCODE, CH_LF);
    send_req(REQ_ENCODE, CH_CR);
    send_req(REQ_ENCODE, CH_LF);
    send_req(REQ_ENCODE, 8'h41);
    send_req(REQ_ENCODE, 8'h80);
    send_req(REQ_ENCODE, CH_LF);
    send_req(REQ_ENCODE, 8'hff);
  endtask

  // Mostly well-formed decode and encode runs, with some noise mixed in.
  task automatic random_traffic(input bit with_pause);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    logic [1:0]  kind;
    logic [7:0]  value;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < ITEMS_PER_PHASE) begin
      if (with_pause && !paused && sent >= ITEMS_PER_PHASE / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      pick    = $urandom_range(0, 99);
      run_len = $urandom_range(1, 6);
      if (pick < 40) begin
        // Selector followed by codes, now and then a stray byte.
        send_req(REQ_DECODE, SELECTOR_BYTE[$urandom_range(0, NQUAD - 1)]);
        repeat (run_len) begin
          if ($urandom_range(0, 9) == 0) value = 8'($urandom_range(0, 255));
          else value = CODE_MAP[0][$urandom_range(0, NCODE - 1)];
          send_req(REQ_DECODE, value);
        end
        sent += run_len + 1;
      end else if (pick < 80) begin
        // Local text with line ends and null bytes well represented.
        repeat (run_len) begin
          case ($urandom_range(0, 9))
            0: value = CH_LF;
            1: value = CH_CR;
            2: value = 8'h00;
            default: value = 8'($urandom_range(0, 255));
          endcase
          send_req(REQ_ENCODE, value);
        end
        sent += run_len;
      end else if (pick < 95) begin
        kind = 2'($urandom_range(0, 3));
        send_req(kind, 8'($urandom_range(0, 255)));
        if (kind != REQ_UNUSED) sent++;
      end else begin
        send_req(REQ_START, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // Receiver: always ready, random stalls, or a repeating ready-and-stall pattern.
  always @(negedge clk_i) begin
    if (stall_cycle % 40 == 0) stall_mode = $urandom_range(0, 2);
    stall_cycle = stall_cycle + 1;
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 2) != 0);
      default: res_if.ready <= (stall_cycle % 5) < 3;
    endcase
  end

  // Every result transfer is checked against the oldest owed byte.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      board.check_result(res_if.out_byte, res_if.is_last, res_if.error_code);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no transfer for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset, then one phase per entry of the register-setting table, then drain and report.
  initial begin
    board           = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_IDX_ASCII;
    cfg_data_i      = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_DECODE;
    req_if.in_byte  = 8'h00;
    res_if.ready    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_config(PHASE_CFG[p][1], PHASE_CFG[p][0]);
      if (p == 0) directed_traffic();
      random_traffic(p == 2);
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
